>>> src/mie_pkg.sv
// Shared opcodes, control codes and stage payload types for the I-type execute pipeline.
package mie_pkg;

  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_BEQL  = 6'h14;
  localparam logic [5:0] OP_BNEL  = 6'h15;
  localparam logic [5:0] OP_BLEZL = 6'h16;
  localparam logic [5:0] OP_BGTZL = 6'h17;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_LWU   = 6'h27;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_LL    = 6'h30;
  localparam logic [5:0] OP_SC    = 6'h38;

  localparam logic [31:0] INSN_BYTES = 32'd4;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_kind_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } mem_size_t;

  typedef enum logic [1:0] {
    EXC_NONE   = 2'd0,
    EXC_OVF    = 2'd1,
    EXC_UNIMPL = 2'd2
  } exc_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_EQ,
    BR_NE,
    BR_LEZ,
    BR_GTZ
  } br_kind_t;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_ADDU,
    ALU_SLT,
    ALU_SLTU,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_LUI,
    ALU_ONE
  } alu_op_t;

  // Decoded controls
  typedef struct packed {
    br_kind_t  br;
    logic      likely;
    alu_op_t   alu;
    mem_kind_t mkind;
    mem_size_t msize;
    logic      lsig;
    logic      unimpl;
  } ctrl_t;

  // Decode stage payload
  typedef struct packed {
    ctrl_t       ctrl;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] boff;
    logic [31:0] rsv;
    logic [31:0] rtv;
    logic [31:0] pc4;
  } dec_t;

  // Execute stage payload
  typedef struct packed {
    logic        is_br;
    logic        likely;
    logic        taken;
    logic        alu_en;
    logic        ovf;
    logic        unimpl;
    logic [31:0] alu_val;
    logic [31:0] ea;
    logic [31:0] target;
    logic [31:0] pc4;
    logic [31:0] pc8;
    logic [4:0]  rt;
    logic [31:0] rtv;
    mem_kind_t   mkind;
    mem_size_t   msize;
    logic        lsig;
  } ex_t;

endpackage

>>> src/mips_itype_execute.sv
// Top level of the MIPS32 I-type execute pipeline.
// 3 register stages: an accepted request is registered in decode, then execute, then the output register.
// Throughput: one request per cycle while the output is not stalled; the three stages hold one request each.
// Stages: decode (pc+4, immediates), execute (32-bit adder, compares, target), format.
// Reset: rst clears all stage valid bits synchronously; payload registers are not reset.
module mips_itype_execute import mie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  input  logic [31:0] rs_value,
  input  logic [31:0] rt_value,
  input  logic [31:0] pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_pc,
  output logic        is_branch,
  output logic        annul_slot,
  output logic        reg_write,
  output logic [4:0]  dest_index,
  output logic [31:0] write_value,
  output logic [1:0]  mem_kind,
  output logic [31:0] mem_address,
  output logic [1:0]  mem_size,
  output logic        load_signed,
  output logic [31:0] store_data,
  output logic [1:0]  exception
);

  // Each stage advances when its successor is empty or draining this cycle,
  // so a stall at the output backs up stage by stage without dropping a request.
  logic dec_valid;
  logic dec_ready;
  dec_t dec;
  logic ex_valid;
  logic ex_ready;
  ex_t  ex;

  // Decode: classify the opcode, extend the immediate, precompute pc+4.
  mie_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .instruction (instruction),
    .rs_value    (rs_value),
    .rt_value    (rt_value),
    .pc          (pc),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec         (dec)
  );

  // Execute: one shared rs+simm adder feeds both the ALU result and the
  // effective address; branch compares and targets resolve here.
  mie_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .ex_valid  (ex_valid),
    .ex_ready  (ex_ready),
    .ex        (ex)
  );

  // Format: drop writes on overflow or r0, zero unused fields, hold the result.
  mie_format u_format (
    .clk         (clk),
    .rst         (rst),
    .ex_valid    (ex_valid),
    .ex_ready    (ex_ready),
    .ex          (ex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_pc     (next_pc),
    .is_branch   (is_branch),
    .annul_slot  (annul_slot),
    .reg_write   (reg_write),
    .dest_index  (dest_index),
    .write_value (write_value),
    .mem_kind    (mem_kind),
    .mem_address (mem_address),
    .mem_size    (mem_size),
    .load_signed (load_signed),
    .store_data  (store_data),
    .exception   (exception)
  );

endmodule

>>> src/mie_decode.sv
// Stage one: opcode decode, immediate extension and pc+4.
module mie_decode import mie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  input  logic [31:0] rs_value,
  input  logic [31:0] rt_value,
  input  logic [31:0] pc,
  output logic        dec_valid,
  input  logic        dec_ready,
  output dec_t        dec
);

  ctrl_t       ctrl_next;
  logic [5:0]  op;
  logic [15:0] imm;
  logic [31:0] simm;

  assign op   = instruction[31:26];
  assign imm  = instruction[15:0];
  assign simm = {{16{imm[15]}}, imm};

  always_comb begin
    ctrl_next        = '0;
    ctrl_next.br     = BR_NONE;
    ctrl_next.alu    = ALU_NONE;
    ctrl_next.mkind  = MEM_NONE;
    ctrl_next.msize  = SIZE_BYTE;
    ctrl_next.likely = op[4];
    unique case (op) inside
      OP_BEQ, OP_BEQL:   ctrl_next.br = BR_EQ;
      OP_BNE, OP_BNEL:   ctrl_next.br = BR_NE;
      OP_BLEZ, OP_BLEZL: ctrl_next.br = BR_LEZ;
      OP_BGTZ, OP_BGTZL: ctrl_next.br = BR_GTZ;
      OP_ADDI:  ctrl_next.alu = ALU_ADD;
      OP_ADDIU: ctrl_next.alu = ALU_ADDU;
      OP_SLTI:  ctrl_next.alu = ALU_SLT;
      OP_SLTIU: ctrl_next.alu = ALU_SLTU;
      OP_ANDI:  ctrl_next.alu = ALU_AND;
      OP_ORI:   ctrl_next.alu = ALU_OR;
      OP_XORI:  ctrl_next.alu = ALU_XOR;
      OP_LUI:   ctrl_next.alu = ALU_LUI;
      OP_LB: begin
        ctrl_next.mkind = MEM_LOAD;
        ctrl_next.lsig  = 1'b1;
      end
      OP_LH: begin
        ctrl_next.mkind = MEM_LOAD;
        ctrl_next.msize = SIZE_HALF;
        ctrl_next.lsig  = 1'b1;
      end
      OP_LW, OP_LWU, OP_LL: begin
        ctrl_next.mkind = MEM_LOAD;
        ctrl_next.msize = SIZE_WORD;
      end
      OP_LBU: ctrl_next.mkind = MEM_LOAD;
      OP_LHU: begin
        ctrl_next.mkind = MEM_LOAD;
        ctrl_next.msize = SIZE_HALF;
      end
      OP_SB: ctrl_next.mkind = MEM_STORE;
      OP_SH: begin
        ctrl_next.mkind = MEM_STORE;
        ctrl_next.msize = SIZE_HALF;
      end
      OP_SW: begin
        ctrl_next.mkind = MEM_STORE;
        ctrl_next.msize = SIZE_WORD;
      end
      OP_SC: begin
        ctrl_next.mkind = MEM_STORE;
        ctrl_next.msize = SIZE_WORD;
        ctrl_next.alu   = ALU_ONE;
      end
      default: ctrl_next.unimpl = 1'b1;
    endcase
  end

  assign in_ready = !dec_valid || dec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ready) begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dec.ctrl <= ctrl_next;
      dec.rt   <= instruction[20:16];
      dec.imm  <= imm;
      dec.simm <= simm;
      dec.boff <= {simm[29:0], 2'b00};
      dec.rsv  <= rs_value;
      dec.rtv  <= rt_value;
      dec.pc4  <= pc + INSN_BYTES;
    end
  end

endmodule

>>> src/mie_exec.sv
// Stage two: adder, compares, logic ops and branch target.
module mie_exec import mie_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic dec_valid,
  output logic dec_ready,
  input  dec_t dec,
  output logic ex_valid,
  input  logic ex_ready,
  output ex_t  ex
);

  logic [31:0] sum;
  logic [31:0] alu_val;
  logic        slt;
  logic        sltu;
  logic        taken;
  logic        rs_zero;

  assign sum     = dec.rsv + dec.simm;
  assign slt     = $signed(dec.rsv) < $signed(dec.simm);
  assign sltu    = dec.rsv < dec.simm;
  assign rs_zero = (dec.rsv == 32'd0);

  always_comb begin
    case (dec.ctrl.br)
      BR_EQ:   taken = (dec.rsv == dec.rtv);
      BR_NE:   taken = (dec.rsv != dec.rtv);
      BR_LEZ:  taken = dec.rsv[31] || rs_zero;
      BR_GTZ:  taken = !dec.rsv[31] && !rs_zero;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    case (dec.ctrl.alu) inside
      ALU_ADD, ALU_ADDU: alu_val = sum;
      ALU_SLT:  alu_val = {31'd0, slt};
      ALU_SLTU: alu_val = {31'd0, sltu};
      ALU_AND:  alu_val = dec.rsv & {16'd0, dec.imm};
      ALU_OR:   alu_val = dec.rsv | {16'd0, dec.imm};
      ALU_XOR:  alu_val = dec.rsv ^ {16'd0, dec.imm};
      ALU_LUI:  alu_val = {dec.imm, 16'd0};
      ALU_ONE:  alu_val = 32'd1;
      default:  alu_val = 32'd0;
    endcase
  end

  assign dec_ready = !ex_valid || ex_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (dec_ready) begin
      ex_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) begin
      ex.is_br   <= (dec.ctrl.br != BR_NONE);
      ex.likely  <= dec.ctrl.likely;
      ex.taken   <= taken;
      ex.alu_en  <= (dec.ctrl.alu != ALU_NONE);
      ex.ovf     <= (dec.ctrl.alu == ALU_ADD) &&
                    (~(dec.rsv[31] ^ dec.simm[31]) & (dec.rsv[31] ^ sum[31]));
      ex.unimpl  <= dec.ctrl.unimpl;
      ex.alu_val <= alu_val;
      ex.ea      <= sum;
      ex.target  <= dec.pc4 + dec.boff;
      ex.pc4     <= dec.pc4;
      ex.pc8     <= dec.pc4 + INSN_BYTES;
      ex.rt      <= dec.rt;
      ex.rtv     <= dec.rtv;
      ex.mkind   <= dec.ctrl.mkind;
      ex.msize   <= dec.ctrl.msize;
      ex.lsig    <= dec.ctrl.lsig;
    end
  end

endmodule

>>> src/mie_format.sv
// Stage three: result masking and the output register.
module mie_format import mie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ex_valid,
  output logic        ex_ready,
  input  ex_t         ex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_pc,
  output logic        is_branch,
  output logic        annul_slot,
  output logic        reg_write,
  output logic [4:0]  dest_index,
  output logic [31:0] write_value,
  output logic [1:0]  mem_kind,
  output logic [31:0] mem_address,
  output logic [1:0]  mem_size,
  output logic        load_signed,
  output logic [31:0] store_data,
  output logic [1:0]  exception
);

  logic alu_ok;
  logic has_mem;
  exc_t exc_next;

  assign alu_ok  = ex.alu_en && !ex.ovf;
  assign has_mem = (ex.mkind != MEM_NONE);

  always_comb begin
    if (ex.ovf) begin
      exc_next = EXC_OVF;
    end else if (ex.unimpl) begin
      exc_next = EXC_UNIMPL;
    end else begin
      exc_next = EXC_NONE;
    end
  end

  assign ex_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_ready) begin
      out_valid <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid && ex_ready) begin
      next_pc     <= !ex.is_br ? ex.pc4 : (ex.taken ? ex.target : ex.pc8);
      is_branch   <= ex.is_br;
      annul_slot  <= ex.is_br && ex.likely && !ex.taken;
      reg_write   <= alu_ok && (ex.rt != 5'd0);
      dest_index  <= (alu_ok || ex.mkind == MEM_LOAD) ? ex.rt : 5'd0;
      write_value <= alu_ok ? ex.alu_val : 32'd0;
      mem_kind    <= ex.mkind;
      mem_address <= has_mem ? ex.ea : 32'd0;
      mem_size    <= ex.msize;
      load_signed <= ex.lsig;
      store_data  <= (ex.mkind == MEM_STORE) ? ex.rtv : 32'd0;
      exception   <= exc_next;
    end
  end

endmodule

>>> src/mie_check.sv
// Port-level assertions for the I-type execute pipeline, bound to the top level.
module mie_check import mie_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] next_pc,
  input logic        is_branch,
  input logic        annul_slot,
  input logic        reg_write,
  input logic [4:0]  dest_index,
  input logic [31:0] write_value,
  input logic [1:0]  mem_kind,
  input logic [1:0]  exception
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(write_value))
    else $error("result changed while stalled");

  // Output is empty the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Overflow suppresses the register write and clears the value.
  a_ovf_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && exception == EXC_OVF |-> !reg_write && write_value == 32'd0)
    else $error("write on addi overflow");

  // Only branches annul, and a register write never targets r0 and never comes with an exception.
  a_annul_branch: assert property (@(posedge clk) disable iff (rst)
    out_valid && annul_slot |-> is_branch && mem_kind == MEM_NONE)
    else $error("annul without branch");

  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_write |-> dest_index != 5'd0 && exception == EXC_NONE)
    else $error("register write to r0 or with exception");

endmodule

bind mips_itype_execute mie_check u_mie_check (.*);
